// ===== design/tga_pkg.sv =====
// Shared types and constants for the TGA stream decoder.
`timescale 1ns / 1ps
package tga_pkg;
  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_FORMAT_ERR = 2'd1;
  localparam logic [1:0] KIND_BUSY_ERR = 2'd2;
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_EXPAND = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] pix_x;
    logic [15:0] pix_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        more_in_run;
    logic        last_pixel;
  } out_item_t;
endpackage

// ===== design/tga_if.sv =====
// Valid/ready stream interfaces for the decoder channels.
`timescale 1ns / 1ps
interface tga_in_if;
  logic valid;
  logic ready;
  tga_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tga_out_if;
  logic valid;
  logic ready;
  tga_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/tga_rle_image_stream_decoder.sv =====
// Top level of the TGA byte-stream decoder with RLE expansion.
// Results are registered: a result appears in the cycle after the request that causes it.
// Throughput: one request per cycle; the result register is refilled in the same
// cycle it is drained, so only a stalled, full output register holds off input.
// Reset: asynchronous, active low; returns the parser to the start of the header.
`timescale 1ns / 1ps
module tga_rle_image_stream_decoder #(
  parameter int COORD_BITS = 16
) (
  input logic clk_i,
  input logic rst_ni,
  tga_in_if.sink in_i,
  tga_out_if.source out_o
);
  typedef enum logic [2:0] {
    PH_HEADER, PH_SKIP, PH_PACKET, PH_BYTES, PH_REPEAT, PH_DONE, PH_DEAD
  } phase_e;

  phase_e phase_q, phase_d;
  logic [4:0] hidx_q, hidx_d;
  logic [7:0] idlen_q, idlen_d, itype_q, itype_d, depth_q, depth_d, skip_q, skip_d;
  logic [15:0] w_q, w_d, h_q, h_d;
  logic [1:0] orient_q, orient_d;
  logic [15:0] col_q, col_d, row_q, row_d;
  logic [COORD_BITS-1:0] x_q, x_d, y_q, y_d;
  logic [7:0] left_q, left_d;
  logic run_q, run_d;
  logic [1:0] bip_q, bip_d;
  logic [31:0] acc_q, acc_d, rpix_q, rpix_d;
  logic ov_q;
  tga_pkg::out_item_t od_q, res;
  logic emit, accept;

  assign in_i.ready = !ov_q || out_o.ready;
  assign accept = in_i.valid && in_i.ready;
  assign out_o.valid = ov_q;
  assign out_o.data = od_q;

  logic [15:0] wm, hm;
  logic [COORD_BITS-1:0] sx;
  logic [7:0] b;
  logic [31:0] px, accn;
  logic [1:0] bipn;
  logic [7:0] leftn;
  logic last, more, do_pix, pend;
  logic [15:0] coln;

  always_comb begin
    b = in_i.data.data_byte;
    phase_d = phase_q; hidx_d = hidx_q; idlen_d = idlen_q; itype_d = itype_q;
    depth_d = depth_q; skip_d = skip_q; w_d = w_q; h_d = h_q; orient_d = orient_q;
    col_d = col_q; row_d = row_q; x_d = x_q; y_d = y_q; left_d = left_q;
    run_d = run_q; bip_d = bip_q; acc_d = acc_q; rpix_d = rpix_q;
    emit = 1'b0; res = '0; do_pix = 1'b0; px = rpix_q; pend = 1'b0;
    wm = w_q; hm = h_q; accn = '0; bipn = '0;
    // Header-end: masked size computed from the bytes as now stored.
    if (phase_q == PH_HEADER && hidx_q == 5'd17) begin
      wm = {{(16-COORD_BITS){1'b0}}, w_q[COORD_BITS-1:0]};
      hm = {{(16-COORD_BITS){1'b0}}, h_q[COORD_BITS-1:0]};
    end
    sx = orient_d[0] ? (wm[COORD_BITS-1:0] - 1'b1) : '0;
    if (accept && phase_q != PH_DONE && phase_q != PH_DEAD) begin
      if (in_i.data.op == tga_pkg::OP_EXPAND) begin
        if (phase_q == PH_REPEAT) do_pix = 1'b1;
      end else begin
        case (phase_q)
          PH_HEADER: begin
            case (hidx_q)
              5'd0: idlen_d = b;
              5'd2: itype_d = b;
              5'd12: w_d[7:0] = b;
              5'd13: w_d[15:8] = b;
              5'd14: h_d[7:0] = b;
              5'd15: h_d[15:8] = b;
              5'd16: depth_d = b;
              5'd17: orient_d = {b[5], b[4]};
              default: ;
            endcase
            if (hidx_q != 5'd17) hidx_d = hidx_q + 5'd1;
            else begin
              w_d = wm; h_d = hm;
              sx = b[4] ? (wm[COORD_BITS-1:0] - 1'b1) : '0;
              if (!(itype_q inside {8'd2, 8'd3, 8'd10, 8'd11}) ||
                  !(depth_q inside {8'd8, 8'd24, 8'd32})) begin
                phase_d = PH_DEAD; emit = 1'b1; res.kind = tga_pkg::KIND_FORMAT_ERR;
              end else if (idlen_q != 8'd0) begin
                skip_d = idlen_q; phase_d = PH_SKIP;
              end else pend = 1'b1;
            end
          end
          PH_SKIP: begin
            skip_d = skip_q - 8'd1;
            if (skip_d == 8'd0) pend = 1'b1;
          end
          PH_PACKET: begin
            run_d = b[7]; left_d = {1'b0, b[6:0]} + 8'd1;
            bip_d = '0; acc_d = '0; phase_d = PH_BYTES;
          end
          PH_REPEAT: begin
            emit = 1'b1; res.kind = tga_pkg::KIND_BUSY_ERR;
          end
          PH_BYTES: begin
            accn = acc_q | ({24'd0, b} << {bip_q, 3'b000});
            bipn = bip_q + 2'd1;
            if (bipn != 2'd0 && {6'd0, bipn} < (depth_q >> 3)) begin
              acc_d = accn; bip_d = bipn;
            end else begin
              acc_d = '0; bip_d = '0; do_pix = 1'b1;
              if (depth_q == 8'd8) px = {8'hFF, accn[7:0], accn[7:0], accn[7:0]};
              else if (depth_q == 8'd24) px = {8'hFF, accn[23:0]};
              else px = accn;
            end
          end
          default: ;
        endcase
      end
    end
    if (pend) begin
      if (wm == 16'd0 || hm == 16'd0) phase_d = PH_DONE;
      else begin
        col_d = '0; row_d = '0; x_d = sx;
        y_d = orient_d[1] ? '0 : (hm[COORD_BITS-1:0] - 1'b1);
        left_d = '0; run_d = 1'b0; bip_d = '0; acc_d = '0;
        phase_d = (itype_d >= 8'd10) ? PH_PACKET : PH_BYTES;
      end
    end
    leftn = (left_q != 8'd0) ? left_q - 8'd1 : 8'd0;
    coln = col_q + 16'd1;
    last = ({1'b0, col_q} + 17'd1 >= {1'b0, w_q}) && ({1'b0, row_q} + 17'd1 >= {1'b0, h_q});
    more = !last && run_q && leftn != 8'd0;
    if (do_pix) begin
      emit = 1'b1; left_d = leftn;
      res.kind = tga_pkg::KIND_PIXEL;
      res.pix_x = 16'(x_q); res.pix_y = 16'(y_q);
      res.red = px[23:16]; res.green = px[15:8]; res.blue = px[7:0];
      res.alpha = px[31:24]; res.more_in_run = more; res.last_pixel = last;
      if (last) phase_d = PH_DONE;
      else begin
        if (coln >= w_q) begin
          col_d = '0; row_d = row_q + 16'd1; x_d = sx;
          y_d = orient_q[1] ? y_q + 1'b1 : y_q - 1'b1;
        end else begin
          col_d = coln; x_d = orient_q[0] ? x_q - 1'b1 : x_q + 1'b1;
        end
        if (more) begin rpix_d = px; phase_d = PH_REPEAT; end
        else if (itype_q >= 8'd10 && leftn == 8'd0) phase_d = PH_PACKET;
        else phase_d = PH_BYTES;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER; hidx_q <= '0; idlen_q <= '0; itype_q <= '0;
      depth_q <= '0; skip_q <= '0; w_q <= '0; h_q <= '0; orient_q <= '0;
      col_q <= '0; row_q <= '0; x_q <= '0; y_q <= '0; left_q <= '0;
      run_q <= 1'b0; bip_q <= '0; acc_q <= '0; rpix_q <= '0; ov_q <= 1'b0;
    end else begin
      phase_q <= phase_d; hidx_q <= hidx_d; idlen_q <= idlen_d; itype_q <= itype_d;
      depth_q <= depth_d; skip_q <= skip_d; w_q <= w_d; h_q <= h_d;
      orient_q <= orient_d; col_q <= col_d; row_q <= row_d; x_q <= x_d; y_q <= y_d;
      left_q <= left_d; run_q <= run_d; bip_q <= bip_d; acc_q <= acc_d;
      rpix_q <= rpix_d;
      if (in_i.ready) ov_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && emit) od_q <= res;
  end
endmodule

// ===== design/tga_checker.sv =====
// Port-level checks for the TGA decoder, bound to the top level.
`timescale 1ns / 1ps
module tga_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input tga_pkg::out_item_t out_data_i
);
  // A waiting result keeps its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed");
  // Input is always taken when the output side drains.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i) else $error("input stalled");
  // Errors carry no coordinates.
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.kind != tga_pkg::KIND_PIXEL |->
    out_data_i.pix_x == 16'd0 && out_data_i.pix_y == 16'd0) else $error("error fields");
  // The last pixel never claims more repeats.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.last_pixel |-> !out_data_i.more_in_run)
    else $error("last/more");
endmodule

bind tga_rle_image_stream_decoder tga_checker u_tga_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_i.valid), .in_ready_i(in_i.ready),
  .out_valid_i(out_o.valid), .out_ready_i(out_o.ready), .out_data_i(out_o.data)
);

// ===== tb/tb_tga_rle_image_stream_decoder.sv =====
// Self-checking testbench for the TGA RLE stream decoder: one image, random packets and stalls.
`timescale 1ns / 1ps
module tb_tga_rle_image_stream_decoder;

  typedef enum logic [2:0] {
    ST_HEADER, ST_SKIP, ST_PACKET, ST_BYTES, ST_REPEAT, ST_DONE, ST_DEAD
  } dec_state_e;

  localparam int IMG_W = 7;
  localparam int IMG_H = 45;
  localparam int ID_LEN = 3;
  localparam int N_ITEMS = 950;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tga_in_if in_if ();
  tga_out_if out_if ();

  tga_rle_image_stream_decoder #(.COORD_BITS(16)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Decoder state as the testbench models it.
  dec_state_e  m_state;
  logic [4:0]  m_hdr_idx;
  logic [7:0]  m_id_len, m_img_type, m_depth, m_skip, m_left;
  logic [15:0] m_width, m_height, m_col, m_row, m_x, m_y;
  logic [1:0]  m_orient, m_byte_idx;
  logic        m_in_run;
  logic [31:0] m_accum, m_run_px;

  tga_pkg::in_item_t  pending_q[$];
  tga_pkg::out_item_t pixel_q[$];
  int n_errors = 0;
  int n_results = 0;
  int n_pixels = 0;
  int n_busy = 0;
  bit hold_off = 1'b0;
  int cycle = 0;

  function automatic logic [15:0] first_col();
    return m_orient[0] ? m_width - 16'd1 : 16'd0;
  endfunction

  function automatic tga_pkg::out_item_t make_result(logic [1:0] kind, logic [31:0] px,
                                                     logic more, logic last);
    tga_pkg::out_item_t r;
    r.kind = kind;
    r.pix_x = (kind == tga_pkg::KIND_PIXEL) ? m_x : 16'd0;
    r.pix_y = (kind == tga_pkg::KIND_PIXEL) ? m_y : 16'd0;
    r.red = px[23:16];
    r.green = px[15:8];
    r.blue = px[7:0];
    r.alpha = px[31:24];
    r.more_in_run = more;
    r.last_pixel = last;
    return r;
  endfunction

  task automatic start_pixels();
    if (m_width == 16'd0 || m_height == 16'd0) begin
      m_state = ST_DONE;
    end else begin
      m_col = '0;
      m_row = '0;
      m_x = first_col();
      m_y = m_orient[1] ? 16'd0 : m_height - 16'd1;
      m_left = '0;
      m_in_run = 1'b0;
      m_byte_idx = '0;
      m_accum = '0;
      m_state = (m_img_type >= 8'd10) ? ST_PACKET : ST_BYTES;
    end
  endtask

  task automatic place_pixel(logic [31:0] px);
    logic last, more;
    if (m_left > 8'd0) m_left = m_left - 8'd1;
    last = (32'(m_col) + 1 >= 32'(m_width)) && (32'(m_row) + 1 >= 32'(m_height));
    more = !last && m_in_run && m_left > 8'd0;
    pixel_q.push_back(make_result(tga_pkg::KIND_PIXEL, px, more, last));
    if (last) begin
      m_state = ST_DONE;
    end else begin
      m_col = m_col + 16'd1;
      if (m_col >= m_width) begin
        m_col = '0;
        m_row = m_row + 16'd1;
        m_x = first_col();
        m_y = m_orient[1] ? m_y + 16'd1 : m_y - 16'd1;
      end else begin
        m_x = m_orient[0] ? m_x - 16'd1 : m_x + 16'd1;
      end
      if (more) begin
        m_run_px = px;
        m_state = ST_REPEAT;
      end else if (m_img_type >= 8'd10 && m_left == 8'd0) begin
        m_state = ST_PACKET;
      end else begin
        m_state = ST_BYTES;
      end
    end
  endtask

  task automatic decode_request(tga_pkg::in_item_t it);
    logic [7:0] b;
    logic [31:0] px;
    int nbytes;
    b = it.data_byte;
    if (m_state == ST_DEAD || m_state == ST_DONE) return;
    if (it.op == tga_pkg::OP_EXPAND) begin
      if (m_state == ST_REPEAT) place_pixel(m_run_px);
      return;
    end
    case (m_state)
      ST_HEADER: begin
        case (m_hdr_idx)
          5'd0: m_id_len = b;
          5'd2: m_img_type = b;
          5'd12: m_width[7:0] = b;
          5'd13: m_width[15:8] = b;
          5'd14: m_height[7:0] = b;
          5'd15: m_height[15:8] = b;
          5'd16: m_depth = b;
          5'd17: m_orient = {b[5], b[4]};
          default: ;
        endcase
        if (m_hdr_idx < 5'd17) begin
          m_hdr_idx = m_hdr_idx + 5'd1;
        end else if (!(m_img_type inside {8'd2, 8'd3, 8'd10, 8'd11}) ||
                     !(m_depth inside {8'd8, 8'd24, 8'd32})) begin
          m_state = ST_DEAD;
          pixel_q.push_back(make_result(tga_pkg::KIND_FORMAT_ERR, 32'd0, 1'b0, 1'b0));
        end else if (m_id_len > 8'd0) begin
          m_skip = m_id_len;
          m_state = ST_SKIP;
        end else begin
          start_pixels();
        end
      end
      ST_SKIP: begin
        m_skip = m_skip - 8'd1;
        if (m_skip == 8'd0) start_pixels();
      end
      ST_PACKET: begin
        m_in_run = b[7];
        m_left = {1'b0, b[6:0]} + 8'd1;
        m_byte_idx = '0;
        m_accum = '0;
        m_state = ST_BYTES;
      end
      ST_REPEAT: pixel_q.push_back(make_result(tga_pkg::KIND_BUSY_ERR, 32'd0, 1'b0, 1'b0));
      ST_BYTES: begin
        nbytes = 32'(m_depth >> 3);
        m_accum = m_accum | (32'(b) << (m_byte_idx * 8));
        m_byte_idx = m_byte_idx + 2'd1;
        if (!(m_byte_idx < nbytes && m_byte_idx != 2'd0)) begin
          px = m_accum;
          m_byte_idx = '0;
          m_accum = '0;
          if (m_depth == 8'd8) px = {8'hFF, px[7:0], px[7:0], px[7:0]};
          else if (m_depth == 8'd24) px = {8'hFF, px[23:0]};
          place_pixel(px);
        end
      end
      default: ;
    endcase
  endtask

  function automatic tga_pkg::in_item_t data_req(logic [7:0] b);
    tga_pkg::in_item_t it;
    it.op = tga_pkg::OP_DATA;
    it.data_byte = b;
    return it;
  endfunction

  function automatic tga_pkg::in_item_t expand_req();
    tga_pkg::in_item_t it;
    it.op = tga_pkg::OP_EXPAND;
    it.data_byte = 8'($urandom);
    return it;
  endfunction

  // Stimulus: one RLE 32-bit image, top-right origin with both origin flags set.
  task automatic add_packet(bit is_run, int count, bit noisy);
    pending_q.push_back(data_req({is_run, 7'(count - 1)}));
    repeat (is_run ? 1 : count) begin
      repeat (4) pending_q.push_back(data_req(8'($urandom)));
    end
    if (is_run) begin
      repeat (count - 1) begin
        if (noisy && $urandom_range(0, 19) == 0)
          pending_q.push_back(data_req(8'($urandom)));
        pending_q.push_back(expand_req());
      end
    end
  endtask

  initial begin
    logic [7:0] hdr[18];
    foreach (hdr[i]) hdr[i] = 8'($urandom);
    hdr[0] = 8'(ID_LEN);
    hdr[2] = 8'd10;
    hdr[12] = 8'(IMG_W);
    hdr[13] = 8'd0;
    hdr[14] = 8'(IMG_H);
    hdr[15] = 8'd0;
    hdr[16] = 8'd32;
    hdr[17] = 8'h30;
    pending_q.push_back(expand_req());
    foreach (hdr[i]) pending_q.push_back(data_req(hdr[i]));
    pending_q.push_back(data_req(8'h00));
    pending_q.push_back(data_req(8'hFF));
    pending_q.push_back(data_req(8'hA5));
    // Raw single pixel of all-ones, then a run with a byte during its repeats.
    pending_q.push_back(expand_req());
    pending_q.push_back(data_req(8'h00));
    repeat (4) pending_q.push_back(data_req(8'hFF));
    pending_q.push_back(data_req(8'h81));
    repeat (4) pending_q.push_back(data_req(8'h00));
    pending_q.push_back(data_req(8'h5A));
    pending_q.push_back(expand_req());
    pending_q.push_back(expand_req());
    // Longest run, crossing many row ends.
    add_packet(1'b1, 128, 1'b0);
    while (pending_q.size() < N_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1)) pending_q.push_back(expand_req());
        else pending_q.push_back(data_req(8'($urandom)));
      end else begin
        add_packet(1'($urandom), $urandom_range(1, 8), 1'b1);
      end
    end
  end

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data <= '0;
      m_state = ST_HEADER;
      m_hdr_idx = '0; m_id_len = '0; m_img_type = '0; m_depth = '0; m_skip = '0;
      m_left = '0; m_width = '0; m_height = '0; m_col = '0; m_row = '0;
      m_x = '0; m_y = '0; m_orient = '0; m_byte_idx = '0; m_in_run = 1'b0;
      m_accum = '0; m_run_px = '0;
    end else begin
      if (in_if.valid && in_if.ready) decode_request(in_if.data);
      if (!in_if.valid || in_if.ready) begin
        if (pending_q.size() > 0 && (cycle < 300 || $urandom_range(0, 99) >= 11)) begin
          in_if.valid <= 1'b1;
          in_if.data <= pending_q.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver.
  always @(posedge clk_i or negedge rst_ni) begin
    tga_pkg::out_item_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      cycle <= cycle + 1;
      if (out_if.valid && out_if.ready) begin
        n_results++;
        if (pixel_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result %p", out_if.data);
        end else begin
          want = pixel_q.pop_front();
          if (want.kind == tga_pkg::KIND_PIXEL) n_pixels++;
          if (want.kind == tga_pkg::KIND_BUSY_ERR) n_busy++;
          if (out_if.data.kind !== want.kind || out_if.data.pix_x !== want.pix_x ||
              out_if.data.pix_y !== want.pix_y || out_if.data.red !== want.red ||
              out_if.data.green !== want.green || out_if.data.blue !== want.blue ||
              out_if.data.alpha !== want.alpha ||
              out_if.data.more_in_run !== want.more_in_run ||
              out_if.data.last_pixel !== want.last_pixel) begin
            n_errors++;
            if (n_errors <= 10) $display("mismatch: expected %p got %p", want, out_if.data);
          end
        end
      end
      out_if.ready <= !hold_off && (cycle < 300 || $urandom_range(0, 99) >= 11);
    end
  end

  // Long receiver stall so the input side backs up.
  initial begin
    int n;
    n = 0;
    wait (cycle == 500);
    hold_off = 1'b1;
    while (n < 200) begin
      @(posedge clk_i);
      n++;
    end
    hold_off = 1'b0;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (cycle > 20 && pending_q.size() == 0 && !in_if.valid);
    wait (pixel_q.size() == 0);
    repeat (20) @(posedge clk_i);
    $display("Decoded one %0dx%0d RLE image: %0d results, %0d pixels, %0d busy flags.",
             IMG_W, IMG_H, n_results, n_pixels, n_busy);
    $display("Random packets, stray expands, receiver stalls and post-image bytes applied.");
    if (n_errors == 0 && pixel_q.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #200000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
